// ----- rtl/iso8601_utc_to_unix_seconds_top_assert.svh -----
// Assertion macros shared by the timestamp converter checkers
`ifndef ISO8601_UTC_TO_UNIX_SECONDS_TOP_ASSERT_SVH
`define ISO8601_UTC_TO_UNIX_SECONDS_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ISO2UNIX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ISO2UNIX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/iso2unix_pkg.sv -----
// Shared types, constants and tables for the timestamp converter
`default_nettype none

package iso2unix_pkg;

  localparam int MAX_FRACTION_DIGITS = 9;
  localparam int NS_DIGITS           = 9;

  localparam int PHASE_W = 5;
  localparam int ACC_W   = 14;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int FRAC_W  = 30;
  localparam int FCNT_W  = 4;
  localparam int UNIX_W  = 39;
  localparam int DAYS_W  = 23;
  localparam int HMS_W   = 17;
  localparam int DOY_W   = 9;
  localparam int Q100_W  = 7;
  localparam int Y365_W  = 22;

  // parser positions
  localparam logic [PHASE_W-1:0] PH_YEAR_END  = 5'd3;
  localparam logic [PHASE_W-1:0] PH_DASH_YM   = 5'd4;
  localparam logic [PHASE_W-1:0] PH_MONTH_END = 5'd6;
  localparam logic [PHASE_W-1:0] PH_DASH_MD   = 5'd7;
  localparam logic [PHASE_W-1:0] PH_DAY_END   = 5'd9;
  localparam logic [PHASE_W-1:0] PH_T_SEP     = 5'd10;
  localparam logic [PHASE_W-1:0] PH_HOUR_END  = 5'd12;
  localparam logic [PHASE_W-1:0] PH_COLON_HM  = 5'd13;
  localparam logic [PHASE_W-1:0] PH_MIN_END   = 5'd15;
  localparam logic [PHASE_W-1:0] PH_COLON_MS  = 5'd16;
  localparam logic [PHASE_W-1:0] PH_SEC_END   = 5'd18;
  localparam logic [PHASE_W-1:0] PH_DOT_OR_Z  = 5'd19;
  localparam logic [PHASE_W-1:0] PH_FRACTION  = 5'd20;
  localparam logic [PHASE_W-1:0] PH_DONE      = 5'd21;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // x/25 = (x*1311) >> 15, exact for x below 2600
  localparam int DIV25_MUL   = 1311;
  localparam int DIV25_SHIFT = 15;

  localparam int YEAR_BIAS     = 400;
  localparam int DAYS_PER_YEAR = 365;
  // days from 0000-03-01 (biased by one 400-year era) to 1970-01-01
  localparam int EPOCH_BIAS    = 865565;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  typedef enum logic [1:0] {
    ST_PARSE,
    ST_CONV1,
    ST_CONV2,
    ST_CONV3
  } ctl_state_t;

  typedef struct packed {
    logic parse_en;
    logic conv1_en;
    logic conv2_en;
    logic load_out;
  } dp_cmd_t;

  function automatic logic is_sep_slot(input logic [PHASE_W-1:0] ph);
    logic r;
    case (ph)
      PH_DASH_YM, PH_DASH_MD, PH_T_SEP, PH_COLON_HM, PH_COLON_MS: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sep_char(input logic [PHASE_W-1:0] ph);
    logic [7:0] r;
    case (ph)
      PH_DASH_YM, PH_DASH_MD:   r = CH_DASH;
      PH_T_SEP:                 r = CH_T;
      PH_COLON_HM, PH_COLON_MS: r = CH_COLON;
      default:                  r = CH_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // day of the year counted from March 1
  function automatic logic [DOY_W-1:0] doy_base(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
    logic [FRAC_W-1:0] r;
    case (n)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/iso2unix_ctrl.sv -----
// Sequencer for character parsing, calendar conversion and result handoff
`default_nettype none

module iso2unix_ctrl
  import iso2unix_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  input  logic    last,
  input  logic    res_ready,
  output logic    char_ready,
  output logic    res_valid,
  output dp_cmd_t cmd
);

  ctl_state_t state, state_next;
  logic       res_valid_next;
  logic       out_free;

  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PARSE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_PARSE: begin
        if (char_valid && last) state_next = ST_CONV1;
      end
      ST_CONV1: state_next = ST_CONV2;
      ST_CONV2: state_next = ST_CONV3;
      ST_CONV3: begin
        if (out_free) state_next = ST_PARSE;
      end
      default: state_next = ST_PARSE;
    endcase
  end

  always_comb begin
    char_ready   = 1'b0;
    cmd          = '0;
    case (state)
      ST_PARSE: begin
        char_ready   = 1'b1;
        cmd.parse_en = char_valid;
      end
      ST_CONV1: cmd.conv1_en = 1'b1;
      ST_CONV2: cmd.conv2_en = 1'b1;
      ST_CONV3: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
    // hold the result beat until taken
    if (cmd.load_out) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iso2unix_dp.sv -----
// Parser registers, field checks and days-from-civil arithmetic
`default_nettype none

module iso2unix_dp
  import iso2unix_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic [7:0]               character,
  output logic                     valid_res,
  output logic signed [UNIX_W-1:0] epoch_secs,
  output logic [FRAC_W-1:0]        frac_nanos
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [ACC_W-1:0]   digit_accum, digit_accum_next;
  logic [YEAR_W-1:0]  year_reg, year_reg_next;
  logic [MONTH_W-1:0] month_reg, month_reg_next;
  logic [DAY_W-1:0]   day_reg, day_reg_next;
  logic [HOUR_W-1:0]  hour_reg, hour_reg_next;
  logic [MIN_W-1:0]   minute_reg, minute_reg_next;
  logic [SEC_W-1:0]   second_reg, second_reg_next;
  logic [FRAC_W-1:0]  fraction_accum, fraction_accum_next;
  logic [FCNT_W-1:0]  fraction_count, fraction_count_next;
  logic               failed, failed_next;

  logic               is_digit;
  logic [3:0]         digit;
  logic [ACC_W-1:0]   acc_step;
  logic [FRAC_W-1:0]  frac_step;

  // conversion pipeline registers
  logic [Q100_W-1:0]        q100_r;
  logic [Y365_W-1:0]        y365_r;
  logic [DOY_W-1:0]         doy_r;
  logic [HMS_W-1:0]         hms_r;
  logic [FRAC_W-1:0]        ns_r;
  logic signed [DAYS_W-1:0] days_r;
  logic                     ok_r;

  logic                     adj;
  logic [YEAR_W-1:0]        year_biased;
  logic [23:0]              div_prod;
  logic [Q100_W-1:0]        q100_c;
  logic [Y365_W-1:0]        y365_c;
  logic [DOY_W-1:0]         doy_c;
  logic [HMS_W-1:0]         hms_c;
  logic [FCNT_W-1:0]        cnt_sat;
  logic [2*FRAC_W-1:0]      ns_prod;

  logic                     y4_zero;
  logic                     r100_zero;
  logic                     q400_zero;
  logic                     leap;
  logic [DAY_W-1:0]         dim;
  logic                     ok_c;
  logic [11:0]              q4_adj;
  logic [7:0]               q100_adj;
  logic [5:0]               q400_adj;
  logic [23:0]              days_u;

  logic signed [DAYS_W+17:0] secs_prod;
  logic [UNIX_W-1:0]         secs_c;

  assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
  assign digit     = 4'(character - CH_ZERO);
  assign acc_step  = ACC_W'(18'(digit_accum) * 18'd10 + 18'(digit));
  assign frac_step = FRAC_W'(34'(fraction_accum) * 34'd10 + 34'(digit));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      digit_accum    <= '0;
      year_reg       <= '0;
      month_reg      <= '0;
      day_reg        <= '0;
      hour_reg       <= '0;
      minute_reg     <= '0;
      second_reg     <= '0;
      fraction_accum <= '0;
      fraction_count <= '0;
      failed         <= 1'b0;
    end else begin
      phase          <= phase_next;
      digit_accum    <= digit_accum_next;
      year_reg       <= year_reg_next;
      month_reg      <= month_reg_next;
      day_reg        <= day_reg_next;
      hour_reg       <= hour_reg_next;
      minute_reg     <= minute_reg_next;
      second_reg     <= second_reg_next;
      fraction_accum <= fraction_accum_next;
      fraction_count <= fraction_count_next;
      failed         <= failed_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    digit_accum_next    = digit_accum;
    year_reg_next       = year_reg;
    month_reg_next      = month_reg;
    day_reg_next        = day_reg;
    hour_reg_next       = hour_reg;
    minute_reg_next     = minute_reg;
    second_reg_next     = second_reg;
    fraction_accum_next = fraction_accum;
    fraction_count_next = fraction_count;
    failed_next         = failed;
    if (cmd.load_out) begin
      // clear the parser for the next string
      phase_next          = '0;
      digit_accum_next    = '0;
      year_reg_next       = '0;
      month_reg_next      = '0;
      day_reg_next        = '0;
      hour_reg_next       = '0;
      minute_reg_next     = '0;
      second_reg_next     = '0;
      fraction_accum_next = '0;
      fraction_count_next = '0;
      failed_next         = 1'b0;
    end else if (cmd.parse_en && !failed) begin
      if (phase < PH_DOT_OR_Z) begin
        if (is_sep_slot(phase)) begin
          if (character != sep_char(phase)) begin
            failed_next = 1'b1;
          end else begin
            phase_next = PHASE_W'(phase + 1'b1);
          end
        end else if (!is_digit) begin
          failed_next = 1'b1;
        end else begin
          phase_next       = PHASE_W'(phase + 1'b1);
          digit_accum_next = '0;
          case (phase)
            PH_YEAR_END: year_reg_next = acc_step;
            PH_MONTH_END: begin
              if (acc_step < 14'd1 || acc_step > 14'd12) failed_next = 1'b1;
              month_reg_next = acc_step[MONTH_W-1:0];
            end
            PH_DAY_END: begin
              if (acc_step < 14'd1 || acc_step > 14'd31) failed_next = 1'b1;
              day_reg_next = acc_step[DAY_W-1:0];
            end
            PH_HOUR_END: begin
              if (acc_step > 14'd23) failed_next = 1'b1;
              hour_reg_next = acc_step[HOUR_W-1:0];
            end
            PH_MIN_END: begin
              if (acc_step > 14'd59) failed_next = 1'b1;
              minute_reg_next = acc_step[MIN_W-1:0];
            end
            PH_SEC_END: begin
              if (acc_step > 14'd60) failed_next = 1'b1;
              second_reg_next = acc_step[SEC_W-1:0];
            end
            default: digit_accum_next = acc_step;
          endcase
        end
      end else if (phase == PH_DOT_OR_Z) begin
        if (character == CH_DOT) begin
          phase_next = PH_FRACTION;
        end else if (character == CH_Z) begin
          phase_next = PH_DONE;
        end else begin
          failed_next = 1'b1;
        end
      end else if (phase == PH_FRACTION) begin
        if (is_digit) begin
          if (fraction_count >= FCNT_W'(MAX_FRACTION_DIGITS)) begin
            failed_next = 1'b1;
          end else begin
            fraction_accum_next = frac_step;
            fraction_count_next = FCNT_W'(fraction_count + 1'b1);
          end
        end else if (character == CH_Z) begin
          phase_next = PH_DONE;
        end else begin
          failed_next = 1'b1;
        end
      end else begin
        // anything after the Z
        failed_next = 1'b1;
      end
    end
  end

  // step 1: year/100, biased year times 365, day of year, time of day, ns scaling
  assign adj         = month_reg <= 4'd2;
  assign year_biased = YEAR_W'(year_reg + YEAR_W'(YEAR_BIAS) - YEAR_W'(adj));
  assign div_prod    = 24'(year_reg[YEAR_W-1:2]) * 24'(DIV25_MUL);
  assign q100_c      = Q100_W'(div_prod >> DIV25_SHIFT);
  assign y365_c      = Y365_W'(Y365_W'(year_biased) * Y365_W'(DAYS_PER_YEAR));
  assign doy_c       = DOY_W'(doy_base(month_reg) + DOY_W'(day_reg) - 9'd1);
  assign hms_c       = HMS_W'(HMS_W'(hour_reg) * HMS_W'(SECS_PER_HOUR)
                     + HMS_W'(minute_reg) * HMS_W'(SECS_PER_MIN)
                     + HMS_W'(second_reg));
  assign cnt_sat     = (fraction_count > FCNT_W'(NS_DIGITS)) ? FCNT_W'(NS_DIGITS)
                                                              : fraction_count;
  assign ns_prod     = fraction_accum * pow10(FCNT_W'(FCNT_W'(NS_DIGITS) - cnt_sat));

  always_ff @(posedge clk) begin
    if (cmd.conv1_en) begin
      q100_r <= q100_c;
      y365_r <= y365_c;
      doy_r  <= doy_c;
      hms_r  <= hms_c;
      ns_r   <= ns_prod[FRAC_W-1:0];
    end
  end

  // step 2: leap year, day range, day count since the epoch
  assign y4_zero   = year_reg[1:0] == 2'b00;
  assign r100_zero = year_reg == YEAR_W'(YEAR_W'(q100_r) * YEAR_W'(100));
  assign q400_zero = r100_zero && (q100_r[1:0] == 2'b00);
  assign leap      = y4_zero && (!r100_zero || q400_zero);
  assign dim       = DAY_W'(month_days(month_reg) + DAY_W'(month_reg == 4'd2 && leap));
  assign ok_c      = !failed && (phase == PH_DONE) && (month_reg >= 4'd1)
                  && (month_reg <= 4'd12) && (day_reg >= 5'd1) && (day_reg <= dim);

  // quotients of the biased year, taken from the quotients of the plain year
  assign q4_adj   = 12'(12'(year_reg[YEAR_W-1:2]) + 12'(YEAR_BIAS / 4)
                  - 12'(adj && y4_zero));
  assign q100_adj = 8'(8'(q100_r) + 8'(YEAR_BIAS / 100) - 8'(adj && r100_zero));
  assign q400_adj = 6'(6'(q100_r[Q100_W-1:2]) + 6'(YEAR_BIAS / 400)
                  - 6'(adj && q400_zero));
  assign days_u   = 24'(24'(y365_r) + 24'(q4_adj) - 24'(q100_adj) + 24'(q400_adj)
                  + 24'(doy_r) - 24'(EPOCH_BIAS));

  always_ff @(posedge clk) begin
    if (cmd.conv2_en) begin
      days_r <= DAYS_W'(days_u);
      ok_r   <= ok_c;
    end
  end

  // step 3: seconds
  assign secs_prod = days_r * $signed(18'(SECS_PER_DAY));
  assign secs_c    = UNIX_W'(secs_prod) + UNIX_W'(hms_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      valid_res  <= ok_r;
      epoch_secs <= ok_r ? secs_c : '0;
      frac_nanos <= ok_r ? ns_r : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/iso8601_utc_to_unix_seconds_top.sv -----
// Converts an ISO-8601 UTC timestamp, one character per beat, into Unix
// seconds and nanoseconds. Characters are taken one per cycle. After the
// character flagged last, the conversion steps follow (year division and
// products, day count, seconds product) during which no character is taken;
// the result register then frees the input side, and only a result still
// untaken when the next string ends stalls the block. Every string ending in
// last gives exactly one result beat; valid_res low means a malformed or
// out-of-range string, with epoch_secs and frac_nanos both zero.
`default_nettype none

module iso8601_utc_to_unix_seconds_top
  import iso2unix_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  output logic                     char_ready,
  input  logic [7:0]               character,
  input  logic                     last,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic                     valid_res,
  output logic signed [UNIX_W-1:0] epoch_secs,
  output logic [FRAC_W-1:0]        frac_nanos
);

  dp_cmd_t cmd;

  iso2unix_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .last       (last),
    .res_ready  (res_ready),
    .char_ready (char_ready),
    .res_valid  (res_valid),
    .cmd        (cmd)
  );

  iso2unix_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .character  (character),
    .valid_res  (valid_res),
    .epoch_secs (epoch_secs),
    .frac_nanos (frac_nanos)
  );

endmodule

`default_nettype wire

// ----- rtl/iso2unix_chk.sv -----
// Port-level checks for the timestamp converter, bound to the top level
`default_nettype none

`include "iso8601_utc_to_unix_seconds_top_assert.svh"

module iso2unix_chk
  import iso2unix_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     char_valid,
  input logic                     char_ready,
  input logic                     last,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic                     valid_res,
  input logic signed [UNIX_W-1:0] epoch_secs,
  input logic [FRAC_W-1:0]        frac_nanos
);

  `ISO2UNIX_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(valid_res) && $stable(epoch_secs) && $stable(frac_nanos), "result beat changed while stalled")

  `ISO2UNIX_ASSERT_NOW(a_invalid_zero, res_valid && !valid_res, epoch_secs == '0 && frac_nanos == '0, "invalid result carries nonzero fields")

  `ISO2UNIX_ASSERT_NOW(a_ns_range, res_valid, frac_nanos < 30'd1000000000, "nanoseconds out of range")

  `ISO2UNIX_ASSERT_NEXT(a_busy_after_last, char_valid && char_ready && last, !char_ready, "character taken during conversion")

endmodule

bind iso8601_utc_to_unix_seconds_top iso2unix_chk u_chk (.*);

`default_nettype wire

// ----- dv/iso8601_utc_to_unix_seconds_top_tb.sv -----
// Testbench for the ISO-8601 timestamp to Unix seconds converter
module iso8601_utc_to_unix_seconds_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iso2unix_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_CHARS  = 570;
  localparam int MIN_STAMPS  = 40;

  typedef struct {
    bit     ok;
    longint secs;
    longint ns;
  } stamp_result_t;

  class stamp_scoreboard;
    logic [PHASE_W-1:0] phase;
    logic [ACC_W-1:0]   acc;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [FRAC_W-1:0]  frac;
    logic [FCNT_W-1:0]  fcnt;
    bit                 failed;
    stamp_result_t      pending_stamps[$];
    int                 errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      phase  = '0;
      acc    = '0;
      year   = '0;
      month  = '0;
      day    = '0;
      hour   = '0;
      minute = '0;
      second = '0;
      frac   = '0;
      fcnt   = '0;
      failed = 1'b0;
    endfunction

    function int pending();
      return pending_stamps.size();
    endfunction

    function void parse_char(logic [7:0] c);
      logic [7:0] sep;
      int         v;
      bit         is_digit;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (phase < PH_DOT_OR_Z) begin
        case (phase)
          PH_DASH_YM, PH_DASH_MD:   sep = CH_DASH;
          PH_T_SEP:                 sep = CH_T;
          PH_COLON_HM, PH_COLON_MS: sep = CH_COLON;
          default:                  sep = CH_NONE;
        endcase
        if (sep == CH_NONE) begin
          if (!is_digit) begin
            failed = 1'b1;
            return;
          end
          acc = ACC_W'(int'(acc) * 10 + int'(c - CH_ZERO));
          v = acc;
          // the last digit of a field closes it; range errors stick
          case (phase)
            PH_YEAR_END: begin
              year = YEAR_W'(v);
              acc = '0;
            end
            PH_MONTH_END: begin
              if (v < 1 || v > 12) failed = 1'b1;
              month = MONTH_W'(v);
              acc = '0;
            end
            PH_DAY_END: begin
              if (v < 1 || v > 31) failed = 1'b1;
              day = DAY_W'(v);
              acc = '0;
            end
            PH_HOUR_END: begin
              if (v > 23) failed = 1'b1;
              hour = HOUR_W'(v);
              acc = '0;
            end
            PH_MIN_END: begin
              if (v > 59) failed = 1'b1;
              minute = MIN_W'(v);
              acc = '0;
            end
            PH_SEC_END: begin
              if (v > 60) failed = 1'b1;
              second = SEC_W'(v);
              acc = '0;
            end
            default: ;
          endcase
        end else if (c != sep) begin
          failed = 1'b1;
          return;
        end
        phase = phase + 1'b1;
      end else if (phase == PH_DOT_OR_Z) begin
        if (c == CH_DOT) phase = PH_FRACTION;
        else if (c == CH_Z) phase = PH_DONE;
        else failed = 1'b1;
      end else if (phase == PH_FRACTION) begin
        if (is_digit) begin
          if (fcnt >= MAX_FRACTION_DIGITS) begin
            failed = 1'b1;
            return;
          end
          frac = FRAC_W'(int'(frac) * 10 + int'(c - CH_ZERO));
          fcnt = fcnt + 1'b1;
        end else if (c == CH_Z) begin
          phase = PH_DONE;
        end else begin
          failed = 1'b1;
        end
      end else begin
        failed = 1'b1;
      end
    endfunction

    // days from civil, shifted so the year starts in March
    function longint epoch_seconds();
      longint y, era, yoe, mp, doy, doe;
      int     m, d;
      m = month;
      d = day;
      y = longint'(year) - ((m <= 2) ? 1 : 0);
      era = ((y >= 0) ? y : y - 399) / 400;
      yoe = y - era * 400;
      mp = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return (era * 146097 + doe - 719468) * 86400 + longint'(hour) * 3600
             + longint'(minute) * 60 + longint'(second);
    endfunction

    function void note_char(logic [7:0] c, bit fin);
      stamp_result_t r;
      int            dim;
      bit            leap_year;
      longint        scale;
      if (!failed) parse_char(c);
      if (!fin) return;
      r.ok = !failed && phase == PH_DONE && month >= 1 && month <= 12;
      if (r.ok) begin
        leap_year = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        case (month)
          4, 6, 9, 11: dim = 30;
          2:           dim = leap_year ? 29 : 28;
          default:     dim = 31;
        endcase
        if (day < 1 || day > dim) r.ok = 1'b0;
      end
      r.secs = 0;
      r.ns = 0;
      if (r.ok) begin
        r.secs = epoch_seconds();
        scale = 1;
        repeat (NS_DIGITS - int'(fcnt)) scale = scale * 10;
        r.ns = longint'(frac) * scale;
      end
      pending_stamps.push_back(r);
      restart();
    endfunction

    task report(string field, longint got, longint want);
      errors++;
      if (errors <= 100) $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    endtask

    task check_result(logic ok, logic [UNIX_W-1:0] secs, logic [FRAC_W-1:0] ns);
      stamp_result_t want;
      if (pending_stamps.size() == 0) begin
        report("result beat with no string pending", ok, 0);
        return;
      end
      want = pending_stamps.pop_front();
      if (ok !== want.ok) report("valid_res", ok, want.ok);
      if (secs !== UNIX_W'(want.secs)) report("epoch_secs", $signed(secs), want.secs);
      if (ns !== FRAC_W'(want.ns)) report("frac_nanos", ns, want.ns);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic [7:0] character = 8'h00;
  logic last = 1'b0;
  logic res_ready = 1'b0;
  logic char_ready;
  logic res_valid;
  logic valid_res;
  logic signed [UNIX_W-1:0] epoch_secs;
  logic [FRAC_W-1:0] frac_nanos;

  stamp_scoreboard sb = new();
  logic [7:0] line_q[$];
  bit idle_en = 1'b1;
  bit stall_en = 1'b1;
  int stall_left = 0;
  int rand_chars = 0;
  int stamps_sent = 0;
  int cycles = 0;

  iso8601_utc_to_unix_seconds_top dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last       (last),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .valid_res  (valid_res),
    .epoch_secs (epoch_secs),
    .frac_nanos (frac_nanos)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: take beats, stall after some of them and now and then at random
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready === 1'b1) begin
      sb.check_result(valid_res, epoch_secs, frac_nanos);
      stall_left = stall_en ? $urandom_range(0, 11) : 0;
    end else if (stall_left == 0 && stall_en && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else begin
      res_ready <= 1'b1;
    end
  end

  task send_byte(logic [7:0] c, bit fin);
    int gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    character <= c;
    last <= fin;
    do @(posedge clk); while (char_ready !== 1'b1);
    sb.note_char(c, fin);
  endtask

  task send_line(bit with_last);
    idle_en = $urandom_range(0, 3) != 0;
    stall_en = $urandom_range(0, 3) != 0;
    foreach (line_q[i]) send_byte(line_q[i], with_last && (i == line_q.size() - 1));
    if (with_last) stamps_sent++;
  endtask

  function void load(string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  task send_text(string s, bit with_last);
    load(s);
    send_line(with_last);
  endtask

  // hold the sender idle until every expected result beat is back
  task wait_drained();
    while (sb.pending() != 0) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function string rand_stamp();
    int    yr, mo, dy, hr, mi, se, nd, pick;
    string s;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       yr = 0;
      1:       yr = 9999;
      2:       yr = $urandom_range(1968, 1971);
      default: yr = $urandom_range(0, 9999);
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    dy = (pick < 7) ? $urandom_range(1, 28) : (pick < 9) ? $urandom_range(29, 31)
                                                          : $urandom_range(0, 99);
    hr = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    se = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", yr, mo, dy, hr, mi, se);
    if ($urandom_range(0, 3) != 0) begin
      s = {s, "."};
      nd = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 11) : $urandom_range(0, 9);
      repeat (nd) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    end
    return {s, "Z"};
  endfunction

  task send_random_line();
    int kind, n;
    bit fin;
    kind = $urandom_range(0, 99);
    fin = 1'b1;
    if (kind < 6) begin
      line_q.delete();
      n = $urandom_range(1, 24);
      repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      load(rand_stamp());
      if (kind >= 80) begin
        case (kind % 4)
          0: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            // cut the string short
            n = $urandom_range(1, line_q.size() - 1);
            while (line_q.size() > n) void'(line_q.pop_back());
          end
          2: repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
          default: fin = 1'b0;
        endcase
      end
    end
    rand_chars += line_q.size();
    send_line(fin);
  endtask

  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_text("1970-01-01T00:00:00Z", 1);
    send_text("0000-01-01T00:00:00Z", 1);
    send_text("9999-12-31T23:59:60.999999999Z", 1);
    send_text("2000-02-29T12:34:56.Z", 1);
    send_text("2024-02-29T01:02:03.5Z", 1);
    send_text("1969-12-31T23:59:59.000000001Z", 1);
    send_text("1900-02-29T00:00:00Z", 1);
    send_text("2023-00-10T00:00:00Z", 1);
    send_text("2023-13-01T00:00:00Z", 1);
    send_text("2023-04-31T00:00:00Z", 1);
    send_text("2023-01-00T00:00:00Z", 1);
    send_text("2023-01-01T24:00:00Z", 1);
    send_text("2023-01-01T00:60:00Z", 1);
    send_text("2023-01-01T00:00:61Z", 1);
    send_text("2023-01-01T00:00:00.1234567890Z", 1);
    send_text("2023-01-01T00:00:00ZX", 1);
    send_text("2023-01-0", 1);
    send_text("2023/01-01T00:00:00Z", 1);
    send_text("2023-01-01T00:00:00z", 1);
    // NUL byte in the middle of the string
    load("2023-01-01T00:00:00Z");
    line_q[5] = 8'h00;
    send_line(1);
    line_q.delete();
    line_q.push_back(8'hFF);
    send_line(1);
    // a string with no last runs into the next one
    send_text("2023-01-01T00:00", 0);
    send_text("1970-01-01T00:00:00Z", 1);
    wait_drained();

    while (rand_chars < RAND_CHARS || stamps_sent < MIN_STAMPS) begin
      send_random_line();
      if (!drained_mid && rand_chars >= RAND_CHARS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
    end
    send_text("2038-01-19T03:14:08Z", 1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/iso2unix_pkg.sv
rtl/iso2unix_ctrl.sv
rtl/iso2unix_dp.sv
rtl/iso8601_utc_to_unix_seconds_top.sv
rtl/iso2unix_chk.sv
dv/iso8601_utc_to_unix_seconds_top_tb.sv
